FILE: hw/rtl/feov_pkg.sv
// ----------------------------------------------------------------------------
// feov_pkg: shared types and constants of the frame energy and orbit verifier
// Holds the frame and result transaction types, the fixed field values of a
// frame, the orbit search state and the mixing step.
// ----------------------------------------------------------------------------
`default_nettype none

package feov_pkg;

	localparam logic [15:0] ORB_MULT      = 16'h1337;
	localparam logic [15:0] CHIRAL_WORD   = 16'h03BF;
	localparam logic [15:0] CARDINAL_WORD = 16'h039F;
	localparam logic [7:0]  HIGH3_BYTE    = 8'h2B;
	localparam logic [7:0]  HIGH4_BYTE    = 8'h2F;
	localparam logic [7:0]  LOW7_BYTE     = 8'hFF;
	localparam logic [7:0]  LOW0_BYTE     = 8'h00;
	localparam logic [3:0]  ORB_MISS      = 4'd15;
	localparam logic [33:0] MISS_SCORE    = 34'd100000;

	typedef struct packed {
		logic [15:0] word_0;
		logic [15:0] word_1;
		logic [15:0] word_2;
		logic [15:0] word_3;
		logic [15:0] word_4;
		logic [15:0] word_5;
		logic [15:0] word_6;
		logic [15:0] word_7;
	} frame_t;

	typedef struct packed {
		logic [33:0] energy;
		logic [33:0] score;
		logic [3:0]  orbit_steps;
		logic [4:0]  fault_bits;
	} result_t;

	// Orbit search state carried down the pipeline. Once hit is set the
	// search is over and cnt holds the final step count.
	typedef struct packed {
		logic [15:0] val;
		logic [15:0] tgt;
		logic [15:0] k;
		logic        hit;
		logic [3:0]  cnt;
	} orb_t;

	function automatic logic [15:0] mix_step(logic [15:0] x, logic [15:0] k);
		return {x[14:0], x[15]} ^ {x[12:0], x[15:13]} ^ {x[1:0], x[15:2]} ^ k;
	endfunction

	function automatic logic [7:0] abs_diff8(logic [7:0] a, logic [7:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [15:0] abs_diff16(logic [15:0] a, logic [15:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/frame_energy_orbit_verifier.sv
// ----------------------------------------------------------------------------
// frame_energy_orbit_verifier: frame energy, fault mask and orbit search
// Computes the squared-error energy of an eight-word frame, its fault mask
// and the number of mixing steps from word_2 to word_5, in a four-stage
// pipeline.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                    Payload            Direction
//   frame     frame_valid / frame_ready    feov_pkg::frame_t  in
//   result    result_valid / result_ready  feov_pkg::result_t out
//
// One frame enters per cycle while frame_ready is high; each result is
// registered through stages 1, 2, 3 and 4 in turn before it is offered. The
// four pipeline stages each run a quarter of the orbit mixing chain next to
// one step of the energy arithmetic (differences, squares, partial sums,
// final sum).
// Reset empties the pipeline. A stall on result_ready holds the full stages
// ahead of the first empty one, and frame_ready drops only when all four
// stages are full and result_ready is low.
`default_nettype none

module frame_energy_orbit_verifier #(
	parameter int ORBIT_STEPS = 14
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                frame_valid,
	output logic               frame_ready,
	input  feov_pkg::frame_t   frame,
	output logic               result_valid,
	input  wire                result_ready,
	output feov_pkg::result_t  result
);

	localparam int NUM_STG = 4;
	localparam int SEG     = (ORBIT_STEPS + NUM_STG - 1) / NUM_STG;

	// Runs the mixing steps numbered first .. first+SEG-1 that fall within
	// the search length. A hit at step 15 or later reads as a miss.
	function automatic feov_pkg::orb_t orb_seg(feov_pkg::orb_t st, int first);
		feov_pkg::orb_t r;
		int             i;
		r = st;
		for (int j = 0; j < SEG; j++) begin
			i = first + j;
			if (i <= ORBIT_STEPS && !r.hit) begin
				r.val = feov_pkg::mix_step(r.val, r.k);
				if (r.val == r.tgt) begin
					r.hit = 1'b1;
					r.cnt = (i < 15) ? 4'(i) : feov_pkg::ORB_MISS;
				end
			end
		end
		return r;
	endfunction

	// Stage control.
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en1, en2, en3, en4;

	assign en4          = !vld_s4 || result_ready;
	assign en3          = !vld_s3 || en4;
	assign en2          = !vld_s2 || en3;
	assign en1          = !vld_s1 || en2;
	assign frame_ready  = en1;
	assign result_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= frame_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	// Front end: level bytes, orbit setup and fault mask.
	logic [7:0]     lvl0, lvl3, lvl4, lvl7;
	logic           lvl_ok;
	feov_pkg::orb_t orb_in;
	logic [4:0]     flt_in;

	always_comb begin
		lvl0   = frame.word_0[15:8];
		lvl3   = frame.word_3[7:0];
		lvl4   = frame.word_4[7:0];
		lvl7   = frame.word_7[15:8];
		lvl_ok = (lvl0 != 8'd0) && (lvl0[7:3] == 5'd0);

		orb_in.val = frame.word_2;
		orb_in.tgt = frame.word_5;
		orb_in.k   = feov_pkg::ORB_MULT * {13'd0, lvl0[2:0]};
		orb_in.hit = !lvl_ok || (frame.word_2 == frame.word_5);
		orb_in.cnt = lvl_ok ? 4'd0 : feov_pkg::ORB_MISS;

		flt_in[0] = (lvl0 != lvl3) || (lvl0 != lvl4) || (lvl0 != lvl7);
		flt_in[1] = frame.word_0[7:0] != feov_pkg::LOW0_BYTE;
		flt_in[2] = frame.word_1 != feov_pkg::CHIRAL_WORD;
		flt_in[3] = frame.word_6 != feov_pkg::CARDINAL_WORD;
		flt_in[4] = frame.word_7[7:0] != feov_pkg::LOW7_BYTE;
	end

	// Stage 1: absolute differences.
	feov_pkg::orb_t orb_s1;
	logic [4:0]     flt_s1;
	logic [7:0]     dl03_s1, dl34_s1, dl47_s1, lo0_s1, dh3_s1, dh4_s1, lo7_s1;
	logic [15:0]    d1_s1, d6_s1;

	always_ff @(posedge clk) begin
		if (en1 && frame_valid) begin
			orb_s1  <= orb_seg(orb_in, 1);
			flt_s1  <= flt_in;
			dl03_s1 <= feov_pkg::abs_diff8(lvl0, lvl3);
			dl34_s1 <= feov_pkg::abs_diff8(lvl3, lvl4);
			dl47_s1 <= feov_pkg::abs_diff8(lvl4, lvl7);
			lo0_s1  <= frame.word_0[7:0];
			dh3_s1  <= feov_pkg::abs_diff8(frame.word_3[15:8], feov_pkg::HIGH3_BYTE);
			dh4_s1  <= feov_pkg::abs_diff8(frame.word_4[15:8], feov_pkg::HIGH4_BYTE);
			lo7_s1  <= feov_pkg::LOW7_BYTE - frame.word_7[7:0];
			d1_s1   <= feov_pkg::abs_diff16(frame.word_1, feov_pkg::CHIRAL_WORD);
			d6_s1   <= feov_pkg::abs_diff16(frame.word_6, feov_pkg::CARDINAL_WORD);
		end
	end

	// Stage 2: squares. The high-byte deviations of words 3 and 4 are whole
	// multiples of 256, so their squares are taken on the byte and shifted later.
	feov_pkg::orb_t orb_s2;
	logic [4:0]     flt_s2;
	logic [15:0]    q03_s2, q34_s2, q47_s2, q0_s2, qh3_s2, qh4_s2, q7_s2;
	logic [31:0]    q1_s2, q6_s2;

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			orb_s2 <= orb_seg(orb_s1, 1 + SEG);
			flt_s2 <= flt_s1;
			q03_s2 <= {8'd0, dl03_s1} * {8'd0, dl03_s1};
			q34_s2 <= {8'd0, dl34_s1} * {8'd0, dl34_s1};
			q47_s2 <= {8'd0, dl47_s1} * {8'd0, dl47_s1};
			q0_s2  <= {8'd0, lo0_s1} * {8'd0, lo0_s1};
			qh3_s2 <= {8'd0, dh3_s1} * {8'd0, dh3_s1};
			qh4_s2 <= {8'd0, dh4_s1} * {8'd0, dh4_s1};
			q7_s2  <= {8'd0, lo7_s1} * {8'd0, lo7_s1};
			q1_s2  <= {16'd0, d1_s1} * {16'd0, d1_s1};
			q6_s2  <= {16'd0, d6_s1} * {16'd0, d6_s1};
		end
	end

	// Stage 3: partial sums.
	feov_pkg::orb_t orb_s3;
	logic [4:0]     flt_s3;
	logic [18:0]    sum_lo_s3;
	logic [16:0]    sum_hi_s3;
	logic [32:0]    sum_wd_s3;

	always_ff @(posedge clk) begin
		if (en3 && vld_s2) begin
			orb_s3    <= orb_seg(orb_s2, 1 + 2 * SEG);
			flt_s3    <= flt_s2;
			sum_lo_s3 <= {3'd0, q03_s2} + {3'd0, q34_s2} + {3'd0, q47_s2}
				+ {3'd0, q0_s2} + {3'd0, q7_s2};
			sum_hi_s3 <= {1'b0, qh3_s2} + {1'b0, qh4_s2};
			sum_wd_s3 <= {1'b0, q1_s2} + {1'b0, q6_s2};
		end
	end

	// Stage 4: final energy and score.
	feov_pkg::orb_t orb_s3x;
	logic [33:0]    energy_c;
	logic [33:0]    score_c;
	logic [3:0]     steps_c;

	always_comb begin
		orb_s3x  = orb_seg(orb_s3, 1 + 3 * SEG);
		// A search that never hit within its length is a miss.
		steps_c  = orb_s3x.hit ? orb_s3x.cnt : feov_pkg::ORB_MISS;
		energy_c = {15'd0, sum_lo_s3} + {1'b0, sum_hi_s3, 16'd0} + {1'b0, sum_wd_s3};
		if (energy_c != 34'd0) begin
			score_c = energy_c;
		end else if (steps_c == feov_pkg::ORB_MISS) begin
			score_c = feov_pkg::MISS_SCORE;
		end else begin
			score_c = 34'd0;
		end
	end

	logic [33:0] energy_s4, score_s4;
	logic [3:0]  steps_s4;
	logic [4:0]  flt_s4;

	always_ff @(posedge clk) begin
		if (en4 && vld_s3) begin
			energy_s4 <= energy_c;
			score_s4  <= score_c;
			steps_s4  <= steps_c;
			flt_s4    <= flt_s3;
		end
	end

	always_comb begin
		result.energy      = energy_s4;
		result.score       = score_s4;
		result.orbit_steps = steps_s4;
		result.fault_bits  = flt_s4;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/feov_chk.sv
// ----------------------------------------------------------------------------
// feov_chk: port-level checks of the frame energy and orbit verifier
// Watches the result channel for handshake behavior and for consistency
// between energy, score, orbit steps and the fault mask.
// ----------------------------------------------------------------------------
`default_nettype none

module feov_chk (
	input wire               clk,
	input wire               arst_n,
	input wire               result_valid,
	input wire               result_ready,
	input feov_pkg::result_t result
);

	// A stalled result transaction stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result_valid dropped while stalled");

	// A stalled result transaction keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result payload changed while stalled");

	// A nonzero energy is the score.
	a_score_energy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.energy != 34'd0 |-> result.score == result.energy)
		else $error("score differs from nonzero energy");

	// With zero energy the score follows the orbit outcome alone.
	a_score_orbit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.energy == 34'd0 |->
		(result.orbit_steps == feov_pkg::ORB_MISS && result.score == feov_pkg::MISS_SCORE)
		|| (result.orbit_steps != feov_pkg::ORB_MISS && result.score == 34'd0))
		else $error("score does not match orbit outcome");

	// A frame with zero energy has every field at its fixed value.
	a_clean_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.energy == 34'd0 |-> result.fault_bits == 5'd0)
		else $error("fault bits set on a zero-energy frame");

endmodule

bind frame_energy_orbit_verifier feov_chk u_feov_chk (.*);

`default_nettype wire

FILE: sim/feov_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// feov_check_pkg: frame prediction and checking for the frame energy verifier
// Holds an independent model of the energy, fault mask and orbit search. It
// also holds frame generators for directed and random stimulus, and the
// result board that pairs each accepted frame with the result it must give.
// ----------------------------------------------------------------------------

package feov_check_pkg;

	import feov_pkg::frame_t;
	import feov_pkg::result_t;

	localparam int          ORBIT_LIMIT  = 14;
	localparam logic [3:0]  STEPS_MISS   = 4'd15;
	localparam logic [15:0] KEY_MULT     = 16'h1337;
	localparam logic [15:0] CHIRAL       = 16'h03BF;
	localparam logic [15:0] CARDINAL     = 16'h039F;
	localparam logic [7:0]  W0_LOW       = 8'h00;
	localparam logic [7:0]  W3_HIGH      = 8'h2B;
	localparam logic [7:0]  W4_HIGH      = 8'h2F;
	localparam logic [7:0]  W7_LOW       = 8'hFF;
	localparam logic [33:0] MISS_PENALTY = 34'd100000;
	localparam int          REPORT_LIMIT = 10;

	// Element 7 is word_0, element 0 is word_7.
	typedef logic [7:0][15:0] word_array_t;

	function automatic logic [63:0] square_gap(logic [63:0] a, logic [63:0] b);
		logic [63:0] d;
		d = (a >= b) ? a - b : b - a;
		return d * d;
	endfunction

	function automatic logic [15:0] orbit_key(logic [7:0] level);
		return level * KEY_MULT;
	endfunction

	function automatic logic [15:0] mix_once(logic [15:0] x, logic [15:0] key);
		logic [15:0] up1, up3, down2;
		up1   = (x << 1) | (x >> 15);
		up3   = (x << 3) | (x >> 13);
		down2 = (x >> 2) | (x << 14);
		return up1 ^ up3 ^ down2 ^ key;
	endfunction

	function automatic logic [15:0] orbit_point(logic [7:0] level, logic [15:0] start, int n);
		logic [15:0] s, key;
		s   = start;
		key = orbit_key(level);
		repeat (n) s = mix_once(s, key);
		return s;
	endfunction

	function automatic logic [3:0] orbit_count(logic [7:0] level, logic [15:0] start,
			logic [15:0] target);
		logic [15:0] s, key;
		if (level < 8'd1 || level > 8'd7)
			return STEPS_MISS;
		key = orbit_key(level);
		if (start == target)
			return 4'd0;
		s = start;
		for (int i = 1; i <= ORBIT_LIMIT; i++) begin
			s = mix_once(s, key);
			// A hit that only comes at step 15 or later still reads as a miss.
			if (s == target)
				return (i < 15) ? 4'(i) : STEPS_MISS;
		end
		return STEPS_MISS;
	endfunction

	function automatic result_t predict_result(frame_t f);
		logic [7:0]  l0, l3, l4, l7;
		logic [63:0] total;
		result_t     r;
		l0 = f.word_0[15:8];
		l3 = f.word_3[7:0];
		l4 = f.word_4[7:0];
		l7 = f.word_7[15:8];
		total = square_gap(l0, l3) + square_gap(l3, l4) + square_gap(l4, l7)
			+ square_gap(f.word_0[7:0], W0_LOW)
			+ square_gap(f.word_1, CHIRAL)
			+ square_gap({f.word_3[15:8], 8'h00}, {W3_HIGH, 8'h00})
			+ square_gap({f.word_4[15:8], 8'h00}, {W4_HIGH, 8'h00})
			+ square_gap(f.word_6, CARDINAL)
			+ square_gap(f.word_7[7:0], W7_LOW);
		r.energy      = total[33:0];
		r.orbit_steps = orbit_count(l0, f.word_2, f.word_5);
		r.fault_bits  = {f.word_7[7:0] != W7_LOW, f.word_6 != CARDINAL, f.word_1 != CHIRAL,
			f.word_0[7:0] != W0_LOW, !(l0 == l3 && l0 == l4 && l0 == l7)};
		if (r.energy != 34'd0)
			r.score = r.energy;
		else
			r.score = (r.orbit_steps == STEPS_MISS) ? MISS_PENALTY : 34'd0;
		return r;
	endfunction

	function automatic frame_t clean_frame(logic [7:0] level, logic [15:0] start,
			logic [15:0] target);
		frame_t f;
		f.word_0 = {level, W0_LOW};
		f.word_1 = CHIRAL;
		f.word_2 = start;
		f.word_3 = {W3_HIGH, level};
		f.word_4 = {W4_HIGH, level};
		f.word_5 = target;
		f.word_6 = CARDINAL;
		f.word_7 = {level, W7_LOW};
		return f;
	endfunction

	// Frames whose target mostly lies on the orbit, some with a level drawn from
	// the whole byte range, some with one or two damaged words, and a share of
	// pure noise.
	function automatic frame_t random_frame();
		word_array_t w;
		logic [7:0]  level;
		logic [15:0] start, target;
		int          pick, slot;
		pick  = $urandom_range(0, 99);
		level = 8'($urandom_range(1, 7));
		start = 16'($urandom);
		if (pick < 8) begin
			w = {$urandom, $urandom, $urandom, $urandom};
			return frame_t'(w);
		end
		if (pick < 16)
			level = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 4) == 0)
			target = 16'($urandom);
		else
			target = orbit_point(level, start, $urandom_range(0, ORBIT_LIMIT));
		w = word_array_t'(clean_frame(level, start, target));
		if (pick >= 60) begin
			repeat ($urandom_range(1, 2)) begin
				slot = $urandom_range(0, 7);
				if ($urandom_range(0, 1) == 1)
					w[slot] = w[slot] ^ (16'd1 << $urandom_range(0, 15));
				else
					w[slot] = 16'($urandom);
			end
		end
		return frame_t'(w);
	endfunction

	class verdict_board;
		result_t expected_q[$];
		int      frames_seen     = 0;
		int      results_checked = 0;
		int      mismatch_count  = 0;

		function void note_frame(frame_t f);
			expected_q.push_back(predict_result(f));
			frames_seen++;
		endfunction

		function void flag(string field, logic [33:0] want, logic [33:0] got);
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("Mismatch in %s of result %0d: expected %0d, got %0d",
					field, results_checked, want, got);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("Result with no frame outstanding: energy %0d score %0d steps %0d faults %0h",
						got.energy, got.score, got.orbit_steps, got.fault_bits);
				return;
			end
			want = expected_q.pop_front();
			if (got.energy !== want.energy)
				flag("energy", want.energy, got.energy);
			if (got.score !== want.score)
				flag("score", want.score, got.score);
			if (got.orbit_steps !== want.orbit_steps)
				flag("orbit_steps", want.orbit_steps, got.orbit_steps);
			if (got.fault_bits !== want.fault_bits)
				flag("fault_bits", want.fault_bits, got.fault_bits);
			results_checked++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

FILE: sim/frame_energy_orbit_verifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_energy_orbit_verifier_tb: self-checking bench for the frame verifier
// Sends a directed set of frames and then random frames through the frame
// channel under three mixes of sender gaps and receiver stalls. Every result
// is checked field by field against a prediction made when its frame was
// taken.
// ----------------------------------------------------------------------------

module frame_energy_orbit_verifier_tb;

	import feov_pkg::frame_t;
	import feov_pkg::result_t;
	import feov_check_pkg::*;

	localparam int RANDOM_FRAMES = 1100;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 12;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    frame_valid  = 1'b0;
	logic    frame_ready;
	frame_t  frame        = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;
	int           cycle_count    = 0;
	verdict_board board;

	frame_energy_orbit_verifier #(
		.ORBIT_STEPS(ORBIT_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame(frame),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, board.pending());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Frames are noted before results are checked, so a transaction on each
	// channel at the same edge is handled in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_valid && frame_ready)
				board.note_frame(frame);
			if (result_valid && result_ready)
				board.check_result(result);
		end
	end

	always @(negedge clk) begin
		result_ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Called and returning at a falling edge. While idle the payload carries
	// noise, which the block must ignore.
	task automatic send_frame(input frame_t f);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			frame_valid <= 1'b0;
			frame       <= {$urandom, $urandom, $urandom, $urandom};
			@(negedge clk);
		end
		frame_valid <= 1'b1;
		frame       <= f;
		@(posedge clk);
		while (!frame_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] lost_target;
		board = new;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct  = 27;
		recv_stall_pct = 87;

		// Well-formed frames: start equals target, early, middle and last step hits.
		send_frame(clean_frame(8'd1, 16'h1234, 16'h1234));
		send_frame(clean_frame(8'd3, 16'hA5A5, orbit_point(8'd3, 16'hA5A5, 1)));
		send_frame(clean_frame(8'd5, 16'h0001, orbit_point(8'd5, 16'h0001, 7)));
		send_frame(clean_frame(8'd7, 16'hFFFF, orbit_point(8'd7, 16'hFFFF, ORBIT_LIMIT)));

		// Well-formed frame whose target is off the orbit.
		lost_target = 16'hBEEF;
		while (orbit_count(8'd4, 16'h0F0F, lost_target) != STEPS_MISS)
			lost_target = lost_target + 16'd1;
		send_frame(clean_frame(8'd4, 16'h0F0F, lost_target));

		// Bad levels miss even when start and target agree.
		send_frame(clean_frame(8'd0, 16'h5555, 16'h5555));
		send_frame(clean_frame(8'd8, 16'h5555, 16'h5555));
		send_frame(clean_frame(8'd255, 16'h0000, 16'h0000));

		send_frame('0);
		send_frame('1);

		// One fault at a time on a level 2 frame.
		send_frame(clean_frame(8'd2, 16'h00F0, 16'h00F0) ^ {16'h0001, 112'd0});
		send_frame(clean_frame(8'd2, 16'h00F0, 16'h00F0) ^ {16'd0, 16'h0001, 96'd0});
		send_frame(clean_frame(8'd2, 16'h00F0, 16'h00F0) ^ {96'd0, 16'h0001, 16'd0});
		send_frame(clean_frame(8'd2, 16'h00F0, 16'h00F0) ^ {112'd0, 16'h0001});
		send_frame(clean_frame(8'd2, 16'h00F0, 16'h00F0) ^ {64'd0, 16'h0001, 48'd0});

		// High bytes of words 3 and 4 carry energy but raise no fault bit.
		send_frame(clean_frame(8'd6, 16'h7777, 16'h7777) ^ {48'd0, 16'h0100, 64'd0});
		send_frame(clean_frame(8'd6, 16'h7777, 16'h7777) ^ {64'd0, 16'h8000, 48'd0});

		// Largest energy the fields allow, then the delimiters at their floor.
		send_frame({16'h00FF, 16'hFFFF, 16'h0000, 16'hFFFF,
			16'hFF00, 16'h0000, 16'hFFFF, 16'hFF00});
		send_frame({16'h0100, 16'h0000, 16'h0000, 16'h2B01,
			16'h2F01, 16'h0000, 16'h0000, 16'h01FF});

		repeat (RANDOM_FRAMES / 3) send_frame(random_frame());
		send_idle_pct  = 87;
		recv_stall_pct = 27;
		repeat (RANDOM_FRAMES / 3) send_frame(random_frame());
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (RANDOM_FRAMES - 2 * (RANDOM_FRAMES / 3)) send_frame(random_frame());
		frame_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Frames taken: %0d, results compared: %0d, mismatches: %0d",
			board.frames_seen, board.results_checked, board.mismatch_count);
		$display("Covered directed frames plus random frames under three gap and stall mixes.");
		if (board.mismatch_count == 0 && board.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
